FILE: design/kqt_pkg.sv
package kqt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned IDX_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_LIST
  } state_t;

  localparam logic signed [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};
  localparam logic signed [QTY_W-1:0] QTY_MIN = {1'b1, {(QTY_W-1){1'b0}}};

endpackage

FILE: design/kqt_if.sv
interface kqt_req_if
  import kqt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [KEY_W-1:0] part_key;
  logic signed [QTY_W-1:0] quantity;

  modport source (output valid, operation, part_key, quantity, input ready);
  modport sink   (input valid, operation, part_key, quantity, output ready);
endinterface

interface kqt_rsp_if
  import kqt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [KEY_W-1:0] result_key;
  logic signed [QTY_W-1:0] result_quantity;
  logic [IDX_OUT_W-1:0]    entry_index;
  logic                    last;

  modport source (output valid, status, result_key, result_quantity, entry_index, last,
                  input ready);
  modport sink   (input valid, status, result_key, result_quantity, entry_index, last,
                  output ready);
endinterface

FILE: design/keyed_quantity_table.sv
// keyed_quantity_table: linear-search table of up to TABLE_DEPTH key/quantity entries.
// in_if carries one request per transaction (insert, search, update, list); out_if
// returns the results, last marking the final result of a request. Both are valid/ready.
// Keys and quantities live in two single-port synchronous memories read one slot per
// cycle. A request is taken only while the block is idle; a finished result may still
// wait in the output register when the next request is accepted.
// Timing: search, update and insert scan slots 0..n-1 in order at one slot per cycle
// (n = entries held) and stop at the first hit or after slot n-1. Update and insert
// write the memory in the cycle that loads the result.
// Insert into a full table and list on an empty table answer without a scan.
// List loads its entries in slot order, one per cycle while the output is not stalled.
// A new request can be taken in the cycle after the final result loads; the longest
// request is a miss on a full table.
// A stalled receiver holds the output register; a finished scan waits in its result
// state and the list stream pauses until the register drains, nothing is dropped.
// Reset empties the table (entry count to zero) and drops any pending result; the
// memories need no clearing since only slots below the entry count are ever read.
module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  kqt_req_if.sink    in_if,
  kqt_rsp_if.source  out_if
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // storage
  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [QTY_W-1:0] qty_mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] key_rd_r;
  logic signed [QTY_W-1:0] qty_rd_r;

  // control
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        addr_r, addr_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic                    hit_r, hit_nxt;
  op_t                     op_r, op_nxt;
  logic signed [KEY_W-1:0] req_key_r, req_key_nxt;
  logic signed [QTY_W-1:0] req_qty_r, req_qty_nxt;

  // output register
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic signed [QTY_W-1:0] out_qty_r;
  logic [IDX_OUT_W-1:0]    out_idx_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    rd_en;
  logic                    rd_consume;
  logic                    key_match;
  logic                    list_last;
  logic                    key_we;
  logic                    qty_we;
  logic [IDX_W-1:0]        wr_idx;
  logic signed [QTY_W-1:0] qty_wdata;
  logic signed [QTY_W:0]   upd_sum;
  logic signed [QTY_W-1:0] upd_sat;
  status_t                 ld_status;
  logic signed [KEY_W-1:0] ld_key;
  logic signed [QTY_W-1:0] ld_qty;
  logic [IDX_OUT_W-1:0]    ld_idx;
  logic                    ld_last;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign key_match = rd_valid_r && (key_rd_r == req_key_r);
  assign list_last = ((CNT_W'(rd_idx_r) + CNT_ONE) == count_r);

  // saturating add for update
  assign upd_sum = {qty_rd_r[QTY_W-1], qty_rd_r} + {req_qty_r[QTY_W-1], req_qty_r};
  assign upd_sat = (upd_sum[QTY_W] != upd_sum[QTY_W-1])
                   ? (upd_sum[QTY_W] ? QTY_MIN : QTY_MAX)
                   : upd_sum[QTY_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    addr_nxt    = addr_r;
    hit_nxt     = hit_r;
    op_nxt      = op_r;
    req_key_nxt = req_key_r;
    req_qty_nxt = req_qty_r;
    rd_en       = 1'b0;
    rd_consume  = 1'b0;
    out_load    = 1'b0;
    key_we      = 1'b0;
    qty_we      = 1'b0;
    wr_idx      = count_r[IDX_W-1:0];
    qty_wdata   = req_qty_r;
    ld_status   = ST_OK;
    ld_key      = req_key_r;
    ld_qty      = req_qty_r;
    ld_idx      = IDX_OUT_W'(count_r[IDX_W-1:0]);
    ld_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_if.operation;
          req_key_nxt = in_if.part_key;
          req_qty_nxt = in_if.quantity;
          addr_nxt    = '0;
          hit_nxt     = 1'b0;
          if (in_if.operation == OP_LIST) begin
            state_nxt = (count_r == '0) ? S_FINISH : S_LIST;
          end else if (in_if.operation == OP_INSERT && count_r == CNT_FULL) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        rd_consume = 1'b1;
        if (key_match) begin
          // read data stays put since no further read is issued
          hit_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if (addr_r == count_r) begin
          state_nxt = S_FINISH;
        end else begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + CNT_ONE;
        end
      end

      S_FINISH: begin
        case (op_r)
          OP_INSERT: begin
            if (count_r == CNT_FULL) begin
              ld_status = ST_FULL;
              ld_qty    = '0;
              ld_idx    = '0;
            end else if (hit_r) begin
              ld_status = ST_EXISTS;
              ld_key    = key_rd_r;
              ld_qty    = qty_rd_r;
              ld_idx    = IDX_OUT_W'(rd_idx_r);
            end
          end
          OP_SEARCH, OP_UPDATE: begin
            if (hit_r) begin
              ld_key = key_rd_r;
              ld_qty = (op_r == OP_UPDATE) ? upd_sat : qty_rd_r;
              ld_idx = IDX_OUT_W'(rd_idx_r);
            end else begin
              ld_status = ST_NOT_FOUND;
              ld_qty    = '0;
              ld_idx    = '0;
            end
          end
          default: begin
            // list on an empty table
            ld_status = ST_NOT_FOUND;
            ld_key    = '0;
            ld_qty    = '0;
            ld_idx    = '0;
          end
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == OP_INSERT && count_r != CNT_FULL && !hit_r) begin
            key_we    = 1'b1;
            qty_we    = 1'b1;
            count_nxt = count_r + CNT_ONE;
          end
          if (op_r == OP_UPDATE && hit_r) begin
            qty_we    = 1'b1;
            wr_idx    = rd_idx_r;
            qty_wdata = upd_sat;
          end
        end
      end

      S_LIST: begin
        ld_status  = ST_OK;
        ld_key     = key_rd_r;
        ld_qty     = qty_rd_r;
        ld_idx     = IDX_OUT_W'(rd_idx_r);
        ld_last    = list_last;
        out_load   = rd_valid_r && out_free;
        rd_consume = out_load;
        if ((addr_r != count_r) && (!rd_valid_r || out_load)) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + CNT_ONE;
        end
        if (out_load && list_last) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_valid_nxt = rd_en || (rd_valid_r && !rd_consume);
    if (accept) begin
      rd_valid_nxt = 1'b0;
    end
    rd_idx_nxt = rd_en ? addr_r[IDX_W-1:0] : rd_idx_r;
  end

  // key and quantity memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= req_key_r;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (qty_we) begin
      qty_mem[wr_idx] <= qty_wdata;
    end
    if (rd_en) begin
      qty_rd_r <= qty_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    hit_r     <= hit_nxt;
    op_r      <= op_nxt;
    req_key_r <= req_key_nxt;
    req_qty_r <= req_qty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key;
      out_qty_r    <= ld_qty;
      out_idx_r    <= ld_idx;
      out_last_r   <= ld_last;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.result_key      = out_key_r;
  assign out_if.result_quantity = out_qty_r;
  assign out_if.entry_index     = out_idx_r;
  assign out_if.last            = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count beyond table depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (addr_r < count_r))
    else $error("read of a slot at or above the entry count");

  a_count_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FINISH) |=> (count_r == $past(count_r)))
    else $error("entry count changed outside a result cycle");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !out_load)
    else $error("result loaded over a pending transaction");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_en && !key_we && !qty_we))
    else $error("memory access while idle");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kqt_pkg::*;

  localparam int SLOTS       = 64;
  localparam int RANDOM_REQS = 480;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] key;
    logic signed [QTY_W-1:0] qty;
    logic [IDX_OUT_W-1:0]    idx;
    logic                    last;
  } entry_result_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [QTY_W-1:0] qty;
    logic                    typed;
    entry_result_t           want;
  } stim_row_t;

  localparam entry_result_t NO_CHECK = '0;

  logic clk;
  logic rst_n;

  kqt_req_if req_ch ();
  kqt_rsp_if rsp_ch ();

  keyed_quantity_table #(
    .TABLE_DEPTH(SLOTS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch.sink),
    .out_if(rsp_ch.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // table shadow
  logic signed [KEY_W-1:0] stored_key [SLOTS];
  logic signed [QTY_W-1:0] stored_qty [SLOTS];
  int                      held;

  entry_result_t           pending_results [$];
  int                      mismatch_count;
  int                      idle_cycles;
  bit                      tx_calm;
  bit                      rx_calm;
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  stim_row_t               directed_rows [17];

  function automatic int find_slot(logic signed [KEY_W-1:0] key);
    for (int i = 0; i < held; i++) begin
      if (stored_key[i] === key) return i;
    end
    return -1;
  endfunction

  // predicts the results of one accepted request and advances the shadow table
  function automatic void apply_request(op_t op, logic signed [KEY_W-1:0] key,
                                        logic signed [QTY_W-1:0] qty);
    int            slot;
    longint        total;
    entry_result_t r;
    r = '{ST_NOT_FOUND, key, '0, '0, 1'b1};
    case (op)
      OP_INSERT: begin
        if (held >= SLOTS) begin
          r = '{ST_FULL, key, '0, '0, 1'b1};
        end else begin
          slot = find_slot(key);
          if (slot >= 0) begin
            r = '{ST_EXISTS, stored_key[slot], stored_qty[slot], 6'(slot), 1'b1};
          end else begin
            stored_key[held] = key;
            stored_qty[held] = qty;
            r = '{ST_OK, key, qty, 6'(held), 1'b1};
            held++;
          end
        end
      end
      OP_SEARCH: begin
        slot = find_slot(key);
        if (slot >= 0) r = '{ST_OK, stored_key[slot], stored_qty[slot], 6'(slot), 1'b1};
      end
      OP_UPDATE: begin
        slot = find_slot(key);
        if (slot >= 0) begin
          total = longint'(stored_qty[slot]) + longint'(qty);
          if (total > longint'(QTY_MAX)) stored_qty[slot] = QTY_MAX;
          else if (total < longint'(QTY_MIN)) stored_qty[slot] = QTY_MIN;
          else stored_qty[slot] = total[QTY_W-1:0];
          r = '{ST_OK, stored_key[slot], stored_qty[slot], 6'(slot), 1'b1};
        end
      end
      default: begin
        if (held == 0) begin
          r = '{ST_NOT_FOUND, '0, '0, '0, 1'b1};
        end else begin
          for (int i = 0; i < held; i++) begin
            pending_results.push_back('{ST_OK, stored_key[i], stored_qty[i], 6'(i),
                                        (i == held - 1)});
          end
          return;
        end
      end
    endcase
    pending_results.push_back(r);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [QTY_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return $urandom_range(0, 200) - 100;
    if (r < 8) return QTY_MAX;
    if (r < 9) return QTY_MIN;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(input op_t op, input logic signed [KEY_W-1:0] key,
                              input logic signed [QTY_W-1:0] qty, input logic typed,
                              input entry_result_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.part_key  <= key;
    req_ch.quantity  <= qty;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(op, key, qty);
    // hand-written expectation replaces the predicted one
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    entry_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d key %0d", rsp_ch.status, rsp_ch.result_key);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
      mismatch_count++;
    end
    if (rsp_ch.result_key !== want.key) begin
      $error("result_key: expected %0d, got %0d", want.key, rsp_ch.result_key);
      mismatch_count++;
    end
    if (rsp_ch.result_quantity !== want.qty) begin
      $error("result_quantity: expected %0d, got %0d", want.qty, rsp_ch.result_quantity);
      mismatch_count++;
    end
    if (rsp_ch.entry_index !== want.idx) begin
      $error("entry_index: expected %0d, got %0d", want.idx, rsp_ch.entry_index);
      mismatch_count++;
    end
    if (rsp_ch.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
      mismatch_count++;
    end
  endtask

  // result side
  initial begin
    int stall;
    int seen;
    seen = 0;
    rx_calm = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      check_result();
      seen++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("keyed_quantity_table test failed");
      $finish;
    end
  end

  initial begin
    logic signed [KEY_W-1:0] key;
    int                      r;
    op_t                     op;

    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.part_key  = '0;
    req_ch.quantity  = '0;
    mismatch_count   = 0;
    held             = 0;
    tx_calm          = 1'b0;

    key_pool[0] = 0;
    key_pool[1] = -1;
    key_pool[2] = QTY_MIN;
    key_pool[3] = QTY_MAX;
    key_pool[4] = 100;
    key_pool[5] = 1;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    directed_rows = '{
      '{OP_LIST,   32'sd0,  32'sd0,  1'b1, '{ST_NOT_FOUND, 32'sd0, 32'sd0, 6'd0, 1'b1}},
      '{OP_SEARCH, 32'sd5,  32'sd0,  1'b1, '{ST_NOT_FOUND, 32'sd5, 32'sd0, 6'd0, 1'b1}},
      '{OP_UPDATE, 32'sd5,  32'sd9,  1'b1, '{ST_NOT_FOUND, 32'sd5, 32'sd0, 6'd0, 1'b1}},
      '{OP_INSERT, QTY_MIN, QTY_MAX, 1'b1, '{ST_OK, QTY_MIN, QTY_MAX, 6'd0, 1'b1}},
      '{OP_INSERT, QTY_MAX, QTY_MIN, 1'b1, '{ST_OK, QTY_MAX, QTY_MIN, 6'd1, 1'b1}},
      '{OP_INSERT, 32'sd0,  32'sd0,  1'b1, '{ST_OK, 32'sd0, 32'sd0, 6'd2, 1'b1}},
      '{OP_INSERT, -32'sd1, 32'sd100, 1'b1, '{ST_OK, -32'sd1, 32'sd100, 6'd3, 1'b1}},
      '{OP_INSERT, QTY_MIN, 32'sd7,  1'b1, '{ST_EXISTS, QTY_MIN, QTY_MAX, 6'd0, 1'b1}},
      '{OP_UPDATE, QTY_MIN, 32'sd1,  1'b1, '{ST_OK, QTY_MIN, QTY_MAX, 6'd0, 1'b1}},
      '{OP_UPDATE, QTY_MAX, -32'sd1, 1'b1, '{ST_OK, QTY_MAX, QTY_MIN, 6'd1, 1'b1}},
      '{OP_UPDATE, -32'sd1, QTY_MIN, 1'b0, NO_CHECK},
      '{OP_UPDATE, 32'sd0,  QTY_MAX, 1'b1, '{ST_OK, 32'sd0, QTY_MAX, 6'd2, 1'b1}},
      '{OP_SEARCH, -32'sd1, 32'sd3,  1'b0, NO_CHECK},
      '{OP_LIST,   32'sd77, 32'sd77, 1'b0, NO_CHECK},
      '{OP_UPDATE, 32'sd0,  QTY_MIN, 1'b1, '{ST_OK, 32'sd0, -32'sd1, 6'd2, 1'b1}},
      '{OP_SEARCH, 32'sh5a5a_a5a5, 32'sd0, 1'b0, NO_CHECK},
      '{OP_LIST,   -32'sd1, -32'sd1, 1'b0, NO_CHECK}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].qty,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // random mix; the table may fill up part way through
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (n % 100 == 99) drain_results();
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_INSERT;
      else if (r < 60) op = OP_SEARCH;
      else if (r < 90) op = OP_UPDATE;
      else op = OP_LIST;
      send_request(op, pick_key(), pick_amount(), 1'b0, NO_CHECK);
    end

    // top up to a full table with fresh keys
    while (held < SLOTS) begin
      do key = $urandom; while (find_slot(key) >= 0);
      send_request(OP_INSERT, key, pick_amount(), 1'b0, NO_CHECK);
    end
    drain_results();
    send_request(OP_INSERT, $urandom, $urandom, 1'b0, NO_CHECK);
    send_request(OP_INSERT, stored_key[0], $urandom, 1'b0, NO_CHECK);
    send_request(OP_SEARCH, stored_key[SLOTS-1], 32'sd0, 1'b0, NO_CHECK);
    send_request(OP_UPDATE, stored_key[SLOTS-1], QTY_MAX, 1'b0, NO_CHECK);
    send_request(OP_LIST, 32'sd0, 32'sd0, 1'b0, NO_CHECK);
    send_request(OP_SEARCH, stored_key[SLOTS/2], 32'sd0, 1'b0, NO_CHECK);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyed_quantity_table test passed");
    end else begin
      $display("keyed_quantity_table test failed");
    end
    $finish;
  end

endmodule

FILE: keyed_quantity_table.f
design/kqt_pkg.sv
design/kqt_if.sv
design/keyed_quantity_table.sv
bench/tb_top.sv
